// ----- hw/rtl/bcds_pkg.sv -----
// Shared types, constants and BCD helper functions for the BCD date stepper.
`default_nettype none
package bcds_pkg;

    localparam int unsigned CenW   = 8;
    localparam int unsigned YearW  = 8;
    localparam int unsigned MonW   = 5;
    localparam int unsigned DayW   = 6;
    localparam int unsigned DateW  = CenW + YearW + MonW + DayW;
    localparam int unsigned TdataW = ((DateW + 7) / 8) * 8;

    localparam logic OpNext = 1'b0;
    localparam logic OpPrev = 1'b1;

    localparam logic [MonW-1:0] MonJan = 5'h01;
    localparam logic [MonW-1:0] MonFeb = 5'h02;
    localparam logic [MonW-1:0] MonApr = 5'h04;
    localparam logic [MonW-1:0] MonJun = 5'h06;
    localparam logic [MonW-1:0] MonSep = 5'h09;
    localparam logic [MonW-1:0] MonOct = 5'h10;
    localparam logic [MonW-1:0] MonNov = 5'h11;
    localparam logic [MonW-1:0] MonDec = 5'h12;

    localparam logic [DayW-1:0] DayFirst = 6'h01;
    localparam logic [DayW-1:0] DayMax   = 6'h31;
    localparam logic [DayW-1:0] Len31    = 6'h31;
    localparam logic [DayW-1:0] Len30    = 6'h30;
    localparam logic [DayW-1:0] Len29    = 6'h29;
    localparam logic [DayW-1:0] Len28    = 6'h28;

    localparam logic [YearW-1:0] Bcd99 = 8'h99;
    localparam logic [YearW-1:0] Bcd00 = 8'h00;

    typedef struct packed {
        logic [CenW-1:0]  century;
        logic [YearW-1:0] year;
        logic [MonW-1:0]  month;
        logic [DayW-1:0]  day;
    } date_t;

    // after decode
    typedef struct packed {
        logic            op;
        date_t           date;
        logic            ok;
        logic            at_end;
        logic            first;
        logic [DayW-1:0] prev_len;
    } dec_t;

    // after day and month
    typedef struct packed {
        logic  op;
        date_t date;
        logic  ystep;
    } dm_t;

    function automatic logic digit_ok(input logic [3:0] d);
        return d <= 4'd9;
    endfunction

    // divisible by 4: (2*tens + ones) mod 4
    function automatic logic is_leap(input logic [YearW-1:0] y);
        logic [1:0] s;
        s = {y[4], 1'b0} + y[1:0];
        return s == 2'd0;
    endfunction

    function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m,
                                                  input logic leap);
        logic [DayW-1:0] len;
        if (m == MonApr || m == MonJun || m == MonSep || m == MonNov) begin
            len = Len30;
        end else if (m == MonFeb) begin
            len = leap ? Len29 : Len28;
        end else begin
            len = Len31;
        end
        return len;
    endfunction

    function automatic logic [MonW-1:0] month_inc(input logic [MonW-1:0] m);
        logic [MonW-1:0] r;
        if (m == MonSep) begin
            r = MonOct;
        end else if (m == MonDec) begin
            r = MonJan;
        end else begin
            r = m + 5'd1;
        end
        return r;
    endfunction

    function automatic logic [MonW-1:0] month_dec(input logic [MonW-1:0] m);
        logic [MonW-1:0] r;
        if (m == MonOct) begin
            r = MonSep;
        end else if (m == MonJan) begin
            r = MonDec;
        end else begin
            r = m - 5'd1;
        end
        return r;
    endfunction

    function automatic logic [DayW-1:0] day_inc(input logic [DayW-1:0] d);
        logic [DayW-1:0] r;
        if (d[3:0] == 4'd9) begin
            r = {d[5:4] + 2'd1, 4'd0};
        end else begin
            r = d + 6'd1;
        end
        return r;
    endfunction

    function automatic logic [DayW-1:0] day_dec(input logic [DayW-1:0] d);
        logic [DayW-1:0] r;
        if (d[3:0] == 4'd0) begin
            r = {d[5:4] - 2'd1, 4'd9};
        end else begin
            r = d - 6'd1;
        end
        return r;
    endfunction

    // two-digit BCD, 99 wraps to 00
    function automatic logic [7:0] bcd_inc(input logic [7:0] v);
        logic [7:0] r;
        if (v[3:0] == 4'd9) begin
            r = {(v[7:4] == 4'd9) ? 4'd0 : v[7:4] + 4'd1, 4'd0};
        end else begin
            r = {v[7:4], v[3:0] + 4'd1};
        end
        return r;
    endfunction

    // two-digit BCD, 00 wraps to 99
    function automatic logic [7:0] bcd_dec(input logic [7:0] v);
        logic [7:0] r;
        if (v[3:0] == 4'd0) begin
            r = {(v[7:4] == 4'd0) ? 4'd9 : v[7:4] - 4'd1, 4'd9};
        end else begin
            r = {v[7:4], v[3:0] - 4'd1};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/bcds_decode.sv -----
// Stage 1: date validity check and month-length comparisons.
`default_nettype none
module bcds_decode (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           in_op,
    input  wire bcds_pkg::date_t in_date,
    output logic                out_valid,
    input  wire logic           out_ready,
    output bcds_pkg::dec_t      out_data
);
    import bcds_pkg::*;

    logic  valid_reg;
    dec_t  data_reg;
    dec_t  data_next;
    logic  leap;

    always_comb begin
        leap               = is_leap(in_date.year);
        data_next.op       = in_op;
        data_next.date     = in_date;
        data_next.ok       = digit_ok(in_date.century[3:0]) && digit_ok(in_date.century[7:4])
                          && digit_ok(in_date.year[3:0]) && digit_ok(in_date.year[7:4])
                          && digit_ok(in_date.month[3:0]) && digit_ok(in_date.day[3:0])
                          && in_date.month >= MonJan && in_date.month <= MonDec
                          && in_date.day >= DayFirst && in_date.day <= DayMax;
        data_next.at_end   = in_date.day >= month_len(in_date.month, leap);
        data_next.first    = in_date.day == DayFirst;
        data_next.prev_len = month_len(month_dec(in_date.month), leap);
    end

    assign in_ready  = ~valid_reg | out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/bcds_daymon.sv -----
// Stage 2: day and month step, flags a year carry or borrow.
`default_nettype none
module bcds_daymon (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire bcds_pkg::dec_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output bcds_pkg::dm_t       out_data
);
    import bcds_pkg::*;

    logic valid_reg;
    dm_t  data_reg;
    dm_t  data_next;

    always_comb begin
        data_next.op    = in_data.op;
        data_next.date  = in_data.date;
        data_next.ystep = 1'b0;
        if (in_data.ok) begin
            if (in_data.op == OpNext) begin
                if (in_data.at_end) begin
                    data_next.date.day   = DayFirst;
                    data_next.date.month = month_inc(in_data.date.month);
                    data_next.ystep      = in_data.date.month == MonDec;
                end else begin
                    data_next.date.day = day_inc(in_data.date.day);
                end
            end else begin
                if (!in_data.first) begin
                    data_next.date.day = day_dec(in_data.date.day);
                end else begin
                    data_next.date.day   = in_data.prev_len;
                    data_next.date.month = month_dec(in_data.date.month);
                    data_next.ystep      = in_data.date.month == MonJan;
                end
            end
        end
    end

    assign in_ready  = ~valid_reg | out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/bcds_yearcen.sv -----
// Stage 3: year and century carry or borrow, output register.
`default_nettype none
module bcds_yearcen (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire bcds_pkg::dm_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output bcds_pkg::date_t     out_date
);
    import bcds_pkg::*;

    logic  valid_reg;
    date_t date_reg;
    date_t date_next;

    always_comb begin
        date_next = in_data.date;
        if (in_data.ystep) begin
            if (in_data.op == OpNext) begin
                date_next.year = bcd_inc(in_data.date.year);
                if (in_data.date.year == Bcd99) begin
                    date_next.century = bcd_inc(in_data.date.century);
                end
            end else begin
                date_next.year = bcd_dec(in_data.date.year);
                if (in_data.date.year == Bcd00) begin
                    date_next.century = bcd_dec(in_data.date.century);
                end
            end
        end
    end

    assign in_ready  = ~valid_reg | out_ready;
    assign out_valid = valid_reg;
    assign out_date  = date_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            date_reg <= date_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/bcd_calendar_date_step.sv -----
// Top level of the BCD calendar date stepper.
// Steps a packed-BCD date one day forward (tuser 0) or back (tuser 1). Dates with
// a bad BCD digit, a month outside 1..12 or a day outside 1..31 come out unchanged.
// Leap years are those whose two-digit year is a multiple of 4. The block is a
// three-stage pipeline (decode, day/month, year/century with output register):
// one item per cycle sustained while m_tready is high, each item passes the stage
// registers in order, and each stage has its own ready so bubbles close up under output stalls.
`default_nettype none
module bcd_calendar_date_step (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // century[7:0], year[15:8], month[20:16], day[26:21], zero pad
    input  wire logic [bcds_pkg::TdataW-1:0]   s_tdata,
    // op[0]
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // century[7:0], year[15:8], month[20:16], day[26:21], zero pad
    output logic [bcds_pkg::TdataW-1:0]        m_tdata
);
    import bcds_pkg::*;

    date_t in_date;
    date_t out_date;
    dec_t  dec_data;
    dm_t   dm_data;
    logic  dec_valid;
    logic  dec_ready;
    logic  dm_valid;
    logic  dm_ready;

    assign in_date.century = s_tdata[CenW-1:0];
    assign in_date.year    = s_tdata[CenW+YearW-1:CenW];
    assign in_date.month   = s_tdata[CenW+YearW+MonW-1:CenW+YearW];
    assign in_date.day     = s_tdata[DateW-1:CenW+YearW+MonW];
    assign m_tdata = {{(TdataW - DateW){1'b0}}, out_date.day, out_date.month,
                      out_date.year, out_date.century};

    bcds_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_date   (in_date),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    bcds_daymon u_daymon (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (dm_valid),
        .out_ready (dm_ready),
        .out_data  (dm_data)
    );

    bcds_yearcen u_yearcen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dm_valid),
        .in_ready  (dm_ready),
        .in_data   (dm_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_date  (out_date)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/bcds_checker.sv -----
// Port-level checks for the BCD date stepper, bound to the top level.
`default_nettype none
module bcds_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [bcds_pkg::TdataW-1:0] m_tdata
);
    import bcds_pkg::*;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("item did not arrive after three cycles");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage empty");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[TdataW-1:DateW] == '0)
        else $error("padding bits set on result");

endmodule

bind bcd_calendar_date_step bcds_checker u_bcds_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
